// ===== src/hpe_pkg.sv =====
`default_nettype none

package hpe_pkg;

  localparam int unsigned OVERFLOW_BUCKET_DEF = 255;

  localparam int unsigned BUCKET_W = 32;
  localparam int unsigned COUNT_W  = 40;
  localparam int unsigned TOTAL_W  = 64;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_OUT_W = 8;

  // bucket value times 100 fits here
  localparam int unsigned SCALED_W = BUCKET_W + 7;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 120;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic done;
    logic ovf;
  } scan_sts_t;

endpackage

`default_nettype wire

// ===== src/hpe_ram.sv =====
`default_nettype none

module hpe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/hpe_scan.sv =====
`default_nettype none

module hpe_scan
  import hpe_pkg::*;
#(
  parameter int unsigned NumBuckets = OVERFLOW_BUCKET_DEF + 1,
  parameter int unsigned TargetW    = BUCKET_W + $clog2(NumBuckets) + PCT_W
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [TargetW-1:0]            target_i,
  input  wire logic [BUCKET_W-1:0]           rdata_i,
  output logic                               rd_en_o,
  output logic      [$clog2(NumBuckets)-1:0] rd_addr_o,
  output logic      [$clog2(NumBuckets)-1:0] bucket_o,
  output scan_sts_t                          sts_o
);

  localparam int unsigned AW = $clog2(NumBuckets);

  logic                active_q;
  logic [AW:0]         issue_q;
  logic                v1_q, v2_q;
  logic [AW-1:0]       idx1_q, idx2_q;
  logic [SCALED_W-1:0] scaled_q;
  logic [TargetW-1:0]  cum_q;
  logic [TargetW-1:0]  cum_sum;
  logic                hit, last, done;

  assign rd_en_o   = active_q && (issue_q != (AW+1)'(NumBuckets));
  assign rd_addr_o = issue_q[AW-1:0];

  // running sum of 100 * count compared against count * percent
  assign cum_sum = cum_q + TargetW'(scaled_q);
  assign hit     = v2_q && (cum_sum >= target_i);
  assign last    = v2_q && (idx2_q == AW'(NumBuckets - 1));
  assign done    = active_q && (hit || last);

  assign bucket_o   = idx2_q;
  assign sts_o.done = done;
  assign sts_o.ovf  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      issue_q  <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else if (start_i) begin
      active_q <= 1'b1;
      issue_q  <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else if (done) begin
      active_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else if (active_q) begin
      if (rd_en_o) begin
        issue_q <= issue_q + 1'b1;
      end
      v1_q <= rd_en_o;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cum_q <= '0;
    end else if (active_q) begin
      idx1_q   <= issue_q[AW-1:0];
      idx2_q   <= idx1_q;
      scaled_q <= (SCALED_W'(rdata_i) << 6) + (SCALED_W'(rdata_i) << 5)
                + (SCALED_W'(rdata_i) << 2);
      if (v2_q) begin
        cum_q <= cum_sum;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/histogram_percentile_engine_core.sv =====
`default_nettype none

// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  operation, sample_ms, percent
// m_axis    out  m_axis_tvalid/m_axis_tready  bucket_index, hit_overflow, sample_count, total_ms
//
// record: one read and one write of the bucket memory port, the write waiting while the output is stalled
// query: the walk reads one bucket a cycle, skipped when the bucket sum or the percent is zero
// clear and reset: every bucket of the memory is zeroed, input held off meanwhile
// a finished result waits in the output register while the next item is taken
// a stalled output holds the block in its final state of the following item

module histogram_percentile_engine_core
  import hpe_pkg::*;
#(
  parameter int unsigned OverflowBucket = OVERFLOW_BUCKET_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // operation, sample_ms, percent, zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // bucket_index, hit_overflow, sample_count, total_ms, zero fill
  output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned NB = OverflowBucket + 1;
  localparam int unsigned AW = $clog2(NB);
  localparam int unsigned SW = BUCKET_W + AW;
  localparam int unsigned TW = SW + PCT_W;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_REC  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;
  logic                 clr_emit_q, clr_emit_d;
  logic [SW-1:0]        bucket_sum_q, bucket_sum_d;
  logic [COUNT_W-1:0]   samples_q, samples_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [AW-1:0]        rec_idx_q, rec_idx_d;
  logic [MS_W-1:0]      rec_ms_q, rec_ms_d;
  logic [TW-1:0]        target_q, target_d;
  logic [AW-1:0]        res_bucket_q, res_bucket_d;
  logic                 res_ovf_q, res_ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic [IDX_OUT_W-1:0] out_bucket_q, out_bucket_d;
  logic                 out_ovf_q, out_ovf_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;
  logic [TOTAL_W-1:0]   out_total_q, out_total_d;

  logic [OP_W-1:0]      in_op;
  logic [MS_W-1:0]      in_ms;
  logic [PCT_W-1:0]     in_pct;
  logic                 in_acc, out_free;
  logic [AW-1:0]        in_idx;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [BUCKET_W-1:0]  ram_wdata, ram_rdata;

  logic                 scan_start, scan_rd_en;
  logic [AW-1:0]        scan_addr, scan_bucket;
  scan_sts_t            scan_sts;

  logic                 bkt_sat;
  logic [COUNT_W-1:0]   samples_inc;
  logic [TOTAL_W:0]     total_add;
  logic [TOTAL_W-1:0]   total_new;

  assign in_op  = s_axis_tdata[OP_W-1:0];
  assign in_ms  = s_axis_tdata[OP_W +: MS_W];
  assign in_pct = s_axis_tdata[OP_W+MS_W +: PCT_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign in_idx = (in_ms >= MS_W'(OverflowBucket)) ? AW'(OverflowBucket) : in_ms[AW-1:0];

  assign bkt_sat     = (ram_rdata == '1);
  assign samples_inc = (samples_q == '1) ? samples_q : samples_q + 1'b1;
  assign total_add   = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(rec_ms_q);
  assign total_new   = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];

  hpe_ram #(
    .Width (BUCKET_W),
    .Depth (NB)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  hpe_scan #(
    .NumBuckets (NB),
    .TargetW    (TW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .target_i  (target_q),
    .rdata_i   (ram_rdata),
    .rd_en_o   (scan_rd_en),
    .rd_addr_o (scan_addr),
    .bucket_o  (scan_bucket),
    .sts_o     (scan_sts)
  );

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    clr_emit_d   = clr_emit_q;
    bucket_sum_d = bucket_sum_q;
    samples_d    = samples_q;
    total_d      = total_q;
    rec_idx_d    = rec_idx_q;
    rec_ms_d     = rec_ms_q;
    target_d     = target_q;
    res_bucket_d = res_bucket_q;
    res_ovf_d    = res_ovf_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_bucket_d = out_bucket_q;
    out_ovf_d    = out_ovf_q;
    out_count_d  = out_count_q;
    out_total_d  = out_total_q;
    ram_we       = 1'b0;
    ram_re       = scan_rd_en;
    ram_addr     = scan_addr;
    ram_wdata    = '0;
    scan_start   = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr_q;
        if (clr_addr_q == AW'(NB - 1)) begin
          clr_addr_d = '0;
          state_d    = clr_emit_q ? ST_DONE : ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_bucket_d = '0;
          res_ovf_d    = 1'b0;
          unique case (in_op)
            OP_RECORD: begin
              ram_re    = 1'b1;
              ram_addr  = in_idx;
              rec_idx_d = in_idx;
              rec_ms_d  = in_ms;
              state_d   = ST_REC;
            end
            OP_QUERY: begin
              if ((bucket_sum_q == '0) || (in_pct == '0)) begin
                state_d = ST_DONE;
              end else begin
                target_d   = TW'(bucket_sum_q) * TW'(in_pct);
                scan_start = 1'b1;
                state_d    = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              bucket_sum_d = '0;
              samples_d    = '0;
              total_d      = '0;
              clr_addr_d   = '0;
              clr_emit_d   = 1'b1;
              state_d      = ST_INIT;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_REC: begin
        ram_addr = rec_idx_q;
        if (out_free) begin
          ram_we       = 1'b1;
          ram_wdata    = bkt_sat ? ram_rdata : ram_rdata + 1'b1;
          bucket_sum_d = bkt_sat ? bucket_sum_q : bucket_sum_q + 1'b1;
          samples_d    = samples_inc;
          total_d      = total_new;
          out_valid_d  = 1'b1;
          out_bucket_d = '0;
          out_ovf_d    = 1'b0;
          out_count_d  = samples_inc;
          out_total_d  = total_new;
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          res_bucket_d = scan_bucket;
          res_ovf_d    = scan_sts.ovf;
          state_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_bucket_d = IDX_OUT_W'(res_bucket_q);
          out_ovf_d    = res_ovf_q;
          out_count_d  = samples_q;
          out_total_d  = total_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      clr_addr_q   <= '0;
      clr_emit_q   <= 1'b0;
      bucket_sum_q <= '0;
      samples_q    <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      clr_emit_q   <= clr_emit_d;
      bucket_sum_q <= bucket_sum_d;
      samples_q    <= samples_d;
      total_q      <= total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_idx_q    <= rec_idx_d;
    rec_ms_q     <= rec_ms_d;
    target_q     <= target_d;
    res_bucket_q <= res_bucket_d;
    res_ovf_q    <= res_ovf_d;
    out_bucket_q <= out_bucket_d;
    out_ovf_q    <= out_ovf_d;
    out_count_q  <= out_count_d;
    out_total_q  <= out_total_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - IDX_OUT_W - 1 - COUNT_W - TOTAL_W)'(0),
                          out_total_q, out_count_q, out_ovf_q, out_bucket_q};

  // memory port is never claimed by a write and a walk read together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && scan_rd_en))
    else $error("memory write collides with walk read");

  // the walk only finishes while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_sts.done |-> (state_q == ST_SCAN))
    else $error("walk finished outside scan state");

  // an accepted record goes to write-back next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_op == OP_RECORD)) |=> (state_q == ST_REC))
    else $error("record did not enter write-back");

  // a clear zeroes the counters before the sweep begins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_op == OP_CLEAR)) |=> ((samples_q == '0) && (total_q == '0)
      && (bucket_sum_q == '0)))
    else $error("clear left counters set");

endmodule

`default_nettype wire
